// ===== hw/rtl/lpp_pkg.sv =====
`timescale 1ns / 1ps

package lpp_pkg;

    localparam int PT_W       = 16;  // Q6.10 point coordinate
    localparam int IMG_W      = 32;  // Q24.8 image coordinate
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_W     = 16;  // Q4.12 transform element
    localparam int MH_W       = 16;  // Q4.12 mount height
    localparam int FP_W       = 32;  // Q16.16 camera constants

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOUNT  = 3'd7;

    // identity transform, unit focal lengths
    localparam logic [CFG_DATA_W-1:0] RST_ROW_X  = 64'h0000_0000_0000_1000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW_Y  = 64'h0000_0000_1000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW_Z  = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ROW_W  = 64'h1000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_FOCAL  = 64'h0001_0000_0001_0000;

    function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_DATA_W-1:0] row,
                                                      input logic [1:0] col);
        coef = signed'(row[col*COEF_W +: COEF_W]);
    endfunction

endpackage

// ===== hw/rtl/lpp_if.sv =====
`timescale 1ns / 1ps

interface lpp_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [lpp_pkg::PT_W-1:0]     point_x;
    logic signed [lpp_pkg::PT_W-1:0]     point_y;
    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface lpp_image_if;
    logic                                valid;
    logic                                ready;
    logic signed [lpp_pkg::IMG_W-1:0]    img_x;
    logic signed [lpp_pkg::IMG_W-1:0]    img_y;
    logic signed [lpp_pkg::IMG_W-1:0]    base_img_x;
    logic signed [lpp_pkg::IMG_W-1:0]    base_img_y;
    logic                                invalid;
    modport source (output valid, img_x, img_y, base_img_x, base_img_y, invalid,
                    input ready);
    modport sink   (input valid, img_x, img_y, base_img_x, base_img_y, invalid,
                    output ready);
endinterface

interface lpp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lpp_pkg::CFG_IDX_W-1:0]       index;
    logic [lpp_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lpp_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Requires i_num < i_den << QUO_W; caller flags the other case.
module lpp_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 35,
    parameter int QUO_W = 32,
    parameter int SB_W  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic [QUO_W-1:0] o_quo,
    output logic [SB_W-1:0]  o_sb
);

    localparam int REM_W = DEN_W + QUO_W;

    logic [REM_W-1:0] r_rem [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0] r_quo [QUO_W+1];
    logic [SB_W-1:0]  r_sb  [QUO_W+1];
    logic [REM_W-1:0] n_rem [QUO_W+1];
    logic [DEN_W-1:0] n_den [QUO_W+1];
    logic [QUO_W-1:0] n_quo [QUO_W+1];
    logic [SB_W-1:0]  n_sb  [QUO_W+1];

    always_comb begin
        logic [REM_W-1:0] shifted;
        logic [REM_W:0]   diff;
        n_rem[0] = REM_W'(i_num);
        n_den[0] = i_den;
        n_quo[0] = '0;
        n_sb[0]  = i_sb;
        for (int s = 0; s < QUO_W; s++) begin
            shifted    = REM_W'(r_den[s]) << (QUO_W - 1 - s);
            diff       = {1'b0, r_rem[s]} - {1'b0, shifted};
            n_den[s+1] = r_den[s];
            n_sb[s+1]  = r_sb[s];
            if (diff[REM_W]) begin
                n_rem[s+1] = r_rem[s];
                n_quo[s+1] = {r_quo[s][QUO_W-2:0], 1'b0};
            end else begin
                n_rem[s+1] = diff[REM_W-1:0];
                n_quo[s+1] = {r_quo[s][QUO_W-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s <= QUO_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_den[s] <= n_den[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    // sideband carries the valid bit, so it is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QUO_W; s++) r_sb[s] <= '0;
        end else if (i_en) begin
            for (int s = 0; s <= QUO_W; s++) r_sb[s] <= n_sb[s];
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_sb  = r_sb[QUO_W];

endmodule

// ===== hw/rtl/laser_point_to_image_projection.sv =====
`timescale 1ns / 1ps

// Laser point to image projection.
// i_pt  : one laser end point (point_x, point_y, Q6.10 m) per word.
// o_img : image coordinates (Q24.8 px) of the point at height zero and at
//         ground height, plus an invalid flag (zero w or z; fields are 0).
// i_cfg : register writes (index, data), always ready; write only when idle.
// Throughput: one word per cycle while the receiver takes each word. The
// pipeline is made of the two bit-serial divider pipelines
// (33 stages for the w divide, 41 for the z divide) plus 8 other stages.
// The whole pipeline advances on one enable: while o_img holds a word that
// the receiver does not take, every stage holds and i_pt.ready is low;
// nothing is lost or repeated.
// Reset clears all valid bits and loads the identity transform, unit focal
// lengths, zero center, shift and mount height.
// Stages: A products, B row sums, C ground point + w check, divide by w,
// E saturate, F focal multiply, G shift add, divide by z, H center/round,
// output register with saturation and invalid zeroing.
module laser_point_to_image_projection (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpp_cfg_if.sink      i_cfg,
    lpp_point_if.sink    i_pt,
    lpp_image_if.source  o_img
);

    // ---------------- configuration registers ----------------
    logic [lpp_pkg::CFG_DATA_W-1:0] r_row [4];
    logic [lpp_pkg::CFG_DATA_W-1:0] r_focal;
    logic [lpp_pkg::CFG_DATA_W-1:0] r_center;
    logic [lpp_pkg::CFG_DATA_W-1:0] r_shift;
    logic [lpp_pkg::MH_W-1:0]       r_mh;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= lpp_pkg::RST_ROW_X;
            r_row[1] <= lpp_pkg::RST_ROW_Y;
            r_row[2] <= lpp_pkg::RST_ROW_Z;
            r_row[3] <= lpp_pkg::RST_ROW_W;
            r_focal  <= lpp_pkg::RST_FOCAL;
            r_center <= '0;
            r_shift  <= '0;
            r_mh     <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lpp_pkg::REG_ROW_X:  r_row[0] <= i_cfg.data;
                lpp_pkg::REG_ROW_Y:  r_row[1] <= i_cfg.data;
                lpp_pkg::REG_ROW_Z:  r_row[2] <= i_cfg.data;
                lpp_pkg::REG_ROW_W:  r_row[3] <= i_cfg.data;
                lpp_pkg::REG_FOCAL:  r_focal  <= i_cfg.data;
                lpp_pkg::REG_CENTER: r_center <= i_cfg.data;
                lpp_pkg::REG_SHIFT:  r_shift  <= i_cfg.data;
                lpp_pkg::REG_MOUNT:  r_mh     <= i_cfg.data[lpp_pkg::MH_W-1:0];
                default: ;
            endcase
        end
    end

    // single pipeline enable
    logic en;
    logic r_o_vld;
    assign en         = !r_o_vld || o_img.ready;
    assign i_pt.ready = en;

    // ---------------- stage A: products ----------------
    // point widened to Q.12; w term is coef * 1.0 = coef << 12
    logic signed [17:0] px, py;
    logic signed [33:0] n_a_p0 [4], n_a_p1 [4], n_a_p2 [4], n_a_p3 [4];
    logic signed [33:0] r_a_p0 [4], r_a_p1 [4], r_a_p2 [4], r_a_p3 [4];
    logic               r_a_vld;

    assign px = {i_pt.point_x, 2'b00};
    assign py = {i_pt.point_y, 2'b00};

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_a_p0[r] = 34'(lpp_pkg::coef(r_row[r], 2'd0)) * 34'(px);
            n_a_p1[r] = 34'(lpp_pkg::coef(r_row[r], 2'd1)) * 34'(py);
            n_a_p2[r] = 34'(lpp_pkg::coef(r_row[r], 2'd2)) * 34'(signed'({1'b0, r_mh}));
            n_a_p3[r] = 34'(lpp_pkg::coef(r_row[r], 2'd3)) <<< 12;
        end
    end

    // ---------------- stage B: sums ----------------
    logic signed [35:0] r_b_top [4];
    logic signed [33:0] r_b_zt  [4];
    logic               r_b_vld;

    // ---------------- stage C: ground point, w check ----------------
    logic signed [35:0] n_c_bot [4];
    logic signed [35:0] r_c_top [4], r_c_bot [4];
    logic               r_c_winv, r_c_vld;

    always_comb begin
        for (int r = 0; r < 4; r++) n_c_bot[r] = r_b_top[r] - 36'(r_b_zt[r]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                r_a_p0[r]  <= n_a_p0[r];
                r_a_p1[r]  <= n_a_p1[r];
                r_a_p2[r]  <= n_a_p2[r];
                r_a_p3[r]  <= n_a_p3[r];
                r_b_top[r] <= 36'(r_a_p0[r]) + 36'(r_a_p1[r]) + 36'(r_a_p3[r]);
                r_b_zt[r]  <= r_a_p2[r];
                r_c_top[r] <= r_b_top[r];
                r_c_bot[r] <= n_c_bot[r];
            end
            r_c_winv <= (r_b_top[3] == '0) || (n_c_bot[3] == '0);
        end
    end

    // ---------------- divide by w ----------------
    // |comp| << 16 / |w|, 32 quotient bits; larger quotients flagged
    logic [50:0] d1_num [2][3];
    logic [34:0] d1_den [2][3];
    logic [3:0]  d1_sb  [2][3];
    logic [31:0] d1_quo [2][3];
    logic [3:0]  d1_osb [2][3];

    always_comb begin
        logic signed [35:0] comp, wv;
        logic [35:0]        cmag, wmag;
        for (int p = 0; p < 2; p++) begin
            for (int c = 0; c < 3; c++) begin
                comp = p[0] ? r_c_bot[c] : r_c_top[c];
                wv   = p[0] ? r_c_bot[3] : r_c_top[3];
                cmag = comp[35] ? 36'(-comp) : 36'(comp);
                wmag = wv[35] ? 36'(-wv) : 36'(wv);
                d1_num[p][c] = {cmag[34:0], 16'b0};
                d1_den[p][c] = wmag[34:0];
                d1_sb[p][c]  = {r_c_vld, r_c_winv, comp[35] ^ wv[35],
                                {16'b0, d1_num[p][c]} >= {wmag[34:0], 32'b0}};
            end
        end
    end

    for (genvar gp = 0; gp < 2; gp++) begin : g_div1_p
        for (genvar gc = 0; gc < 3; gc++) begin : g_div1_c
            lpp_div #(.NUM_W(51), .DEN_W(35), .QUO_W(32), .SB_W(4)) u_div1 (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_num   (d1_num[gp][gc]),
                .i_den   (d1_den[gp][gc]),
                .i_sb    (d1_sb[gp][gc]),
                .o_quo   (d1_quo[gp][gc]),
                .o_sb    (d1_osb[gp][gc])
            );
        end
    end

    // ---------------- stage E: saturate to 32 bits ----------------
    logic signed [31:0] n_e_d [2][3];
    logic               n_e_vld, n_e_winv;
    logic signed [31:0] r_e_d [2][3];
    logic               r_e_vld, r_e_winv;

    always_comb begin
        n_e_vld  = 1'b0;
        n_e_winv = 1'b0;
        for (int p = 0; p < 2; p++) begin
            for (int c = 0; c < 3; c++) begin
                n_e_vld  = n_e_vld  | d1_osb[p][c][3];
                n_e_winv = n_e_winv | d1_osb[p][c][2];
                if (!d1_osb[p][c][1]) begin
                    n_e_d[p][c] = (d1_osb[p][c][0] || d1_quo[p][c][31])
                                  ? 32'sh7FFF_FFFF : signed'(d1_quo[p][c]);
                end else begin
                    n_e_d[p][c] = (d1_osb[p][c][0] || (d1_quo[p][c] > 32'h8000_0000))
                                  ? 32'sh8000_0000 : signed'(-d1_quo[p][c]);
                end
            end
        end
    end

    // ---------------- stage F: focal multiply ----------------
    logic signed [63:0] r_f_m  [2][2];
    logic signed [31:0] r_f_zd [2];
    logic               r_f_inv, r_f_vld;

    // ---------------- stage G: add shift ----------------
    logic signed [63:0] r_g_n  [2][2];
    logic signed [31:0] r_g_zd [2];
    logic               r_g_inv, r_g_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_d    <= n_e_d;
            r_e_winv <= n_e_winv;
            for (int p = 0; p < 2; p++) begin
                for (int k = 0; k < 2; k++) begin
                    r_f_m[p][k] <= 64'(signed'(r_focal[32*k +: 32])) * 64'(r_e_d[p][k]);
                    r_g_n[p][k] <= r_f_m[p][k] + (64'(signed'(r_shift[32*k +: 32])) <<< 16);
                end
                r_f_zd[p] <= r_e_d[p][2];
                r_g_zd[p] <= r_f_zd[p];
            end
            // zero z after dehomogenizing also makes the word invalid
            r_f_inv <= r_e_winv || (r_e_d[0][2] == '0) || (r_e_d[1][2] == '0);
            r_g_inv <= r_f_inv;
        end
    end

    // ---------------- divide by z ----------------
    // 40 quotient bits; anything at or above 2^40 saturates the pixel anyway
    logic [62:0] d2_num [2][2];
    logic [31:0] d2_den [2][2];
    logic [3:0]  d2_sb  [2][2];
    logic [39:0] d2_quo [2][2];
    logic [3:0]  d2_osb [2][2];

    always_comb begin
        logic [63:0] nmag;
        logic [31:0] zmag;
        for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < 2; k++) begin
                nmag = r_g_n[p][k][63] ? 64'(-r_g_n[p][k]) : 64'(r_g_n[p][k]);
                zmag = r_g_zd[p][31] ? 32'(-r_g_zd[p]) : 32'(r_g_zd[p]);
                d2_num[p][k] = nmag[62:0];
                d2_den[p][k] = zmag;
                d2_sb[p][k]  = {r_g_vld, r_g_inv, r_g_n[p][k][63] ^ r_g_zd[p][31],
                                {9'b0, nmag[62:0]} >= {zmag, 40'b0}};
            end
        end
    end

    for (genvar gp = 0; gp < 2; gp++) begin : g_div2_p
        for (genvar gk = 0; gk < 2; gk++) begin : g_div2_k
            lpp_div #(.NUM_W(63), .DEN_W(32), .QUO_W(40), .SB_W(4)) u_div2 (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_num   (d2_num[gp][gk]),
                .i_den   (d2_den[gp][gk]),
                .i_sb    (d2_sb[gp][gk]),
                .o_quo   (d2_quo[gp][gk]),
                .o_sb    (d2_osb[gp][gk])
            );
        end
    end

    // ---------------- stage H: add center and half a Q.8 LSB ----------------
    logic signed [42:0] n_h_s [2][2];
    logic               n_h_vld, n_h_inv;
    logic signed [42:0] r_h_s [2][2];
    logic               r_h_vld, r_h_inv;

    always_comb begin
        logic signed [41:0] q;
        n_h_vld = 1'b0;
        n_h_inv = 1'b0;
        for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < 2; k++) begin
                n_h_vld = n_h_vld | d2_osb[p][k][3];
                n_h_inv = n_h_inv | d2_osb[p][k][2];
                if (d2_osb[p][k][0]) begin
                    q = d2_osb[p][k][1] ? -(42'sd1 <<< 40) : (42'sd1 <<< 40);
                end else begin
                    q = d2_osb[p][k][1] ? -signed'({2'b0, d2_quo[p][k]})
                                        : signed'({2'b0, d2_quo[p][k]});
                end
                n_h_s[p][k] = 43'(q) + 43'(signed'(r_center[32*k +: 32])) + 43'sd128;
            end
        end
    end

    // ---------------- output: floor to Q.8, saturate, zero if invalid ----
    logic signed [31:0] n_o_pix [2][2];
    logic signed [31:0] r_o_pix [2][2];
    logic               r_o_inv;

    always_comb begin
        logic signed [34:0] f;
        for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < 2; k++) begin
                f = 35'(r_h_s[p][k] >>> 8);
                if (r_h_inv) begin
                    n_o_pix[p][k] = '0;
                end else if (f > 35'sh0_7FFF_FFFF) begin
                    n_o_pix[p][k] = 32'sh7FFF_FFFF;
                end else if (f < -35'sh0_8000_0000) begin
                    n_o_pix[p][k] = 32'sh8000_0000;
                end else begin
                    n_o_pix[p][k] = f[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_s   <= n_h_s;
            r_h_inv <= n_h_inv;
            r_o_pix <= n_o_pix;
            r_o_inv <= r_h_inv;
        end
    end

    // valid bits outside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_pt.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_e_vld <= n_e_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= n_h_vld;
            r_o_vld <= r_h_vld;
        end
    end

    assign o_img.valid      = r_o_vld;
    assign o_img.img_x      = r_o_pix[0][0];
    assign o_img.img_y      = r_o_pix[0][1];
    assign o_img.base_img_x = r_o_pix[1][0];
    assign o_img.base_img_y = r_o_pix[1][1];
    assign o_img.invalid    = r_o_inv;

endmodule
